// ===== src/qbt_pkg.sv =====
// Shared constants, payload types and job record for the quadratic Bezier tessellator.
// No dependencies; every other source file imports this package.
`default_nettype none

package qbt_pkg;

  // Field widths.
  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 6;
  localparam int STEP_BITS  = 6;
  localparam int SAMPLE_W   = 16;

  // Arithmetic widths of the forward-difference stepper.
  localparam int DEN_W = 2 * STEP_BITS;                        // n*n
  localparam int DIV_W = STEP_BITS + COORD_BITS + FRAC_BITS + 1; // numerator magnitude
  localparam int NUM_W = DIV_W + 1;                            // signed numerator
  localparam int ACC_W = DIV_W + 2;                            // signed quotients
  localparam int Q0_W  = COORD_BITS + FRAC_BITS;

  localparam int JOB_DEPTH  = 2;
  localparam int OBUF_DEPTH = 2;

  localparam logic [SAMPLE_W-1:0]  OUT_MAX       = '1;
  localparam logic [STEP_BITS-1:0] DEFAULT_STEPS = STEP_BITS'(40);

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_STEPS = '0;

  // Item kinds.
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Point-chaining phase codes.
  localparam logic [1:0] PH_EMPTY = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_CTRL  = 2'd2;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
  } item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
    logic                last_sample;
  } result_t;

  // Floor quotient and non-negative remainder of a division by n*n.
  typedef struct packed {
    logic signed [ACC_W-1:0] quo;
    logic [DEN_W-1:0]        rem;
  } div_res_t;

  // Per-axis start values of the stepper.
  typedef struct packed {
    logic [Q0_W-1:0]         q0;
    logic signed [ACC_W-1:0] dq;
    logic [DEN_W-1:0]        dr;
    logic signed [ACC_W-1:0] sq;
    logic [DEN_W-1:0]        sr;
  } axis_job_t;

  typedef struct packed {
    logic [STEP_BITS-1:0] n;
    logic [DEN_W-1:0]     d;
    axis_job_t            x;
    axis_job_t            y;
  } job_t;

endpackage

`default_nettype wire

// ===== src/qbt_div.sv =====
// Bit-serial signed divider: one quotient bit per cycle, floor result with remainder.
// Depends on qbt_pkg.
`default_nettype none

module qbt_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [qbt_pkg::NUM_W-1:0] num,
  input  logic [qbt_pkg::DEN_W-1:0]        den,
  output logic                             busy,
  output qbt_pkg::div_res_t                res
);
  import qbt_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]        work;
  logic [DEN_W-1:0]        rem;
  logic [DEN_W-1:0]        dsr;
  logic                    neg;
  logic [CNT_W-1:0]        cnt;
  logic signed [NUM_W-1:0] num_abs;
  logic [DEN_W:0]          shifted;
  logic                    ge;
  logic signed [ACC_W-1:0] q_pos;

  assign num_abs = num[NUM_W-1] ? -num : num;
  assign shifted = {rem, work[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= num_abs[DIV_W-1:0];
      rem  <= '0;
      dsr  <= den;
      neg  <= num[NUM_W-1];
    end else if (busy) begin
      work <= {work[DIV_W-2:0], ge};
      rem  <= ge ? DEN_W'(shifted - {1'b0, dsr}) : shifted[DEN_W-1:0];
    end
  end

  // A negative numerator with a nonzero remainder rounds one further down.
  assign q_pos = $signed({{(ACC_W-DIV_W){1'b0}}, work});

  always_comb begin
    if (neg && (rem != '0)) begin
      res.quo = -q_pos - ACC_W'(1);
      res.rem = dsr - rem;
    end else if (neg) begin
      res.quo = -q_pos;
      res.rem = rem;
    end else begin
      res.quo = q_pos;
      res.rem = rem;
    end
  end

endmodule

`default_nettype wire

// ===== src/qbt_front.sv =====
// Front end: accepts items, chains points into segments and prepares stepper jobs.
// Depends on qbt_pkg and qbt_div.
`default_nettype none

module qbt_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [qbt_pkg::STEP_BITS-1:0]   steps,
  input  logic                            push,
  output logic                            full,
  input  qbt_pkg::item_t                  item,
  output logic                            job_push,
  input  logic                            job_full,
  output qbt_pkg::job_t                   job
);
  import qbt_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_PREP = 4'b0010,
    F_DIV  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state, state_next;

  logic [1:0]            phase;
  logic [COORD_BITS-1:0] start_x, start_y, control_x, control_y;
  logic [COORD_BITS-1:0] seg_x0, seg_y0;
  logic [STEP_BITS-1:0]  seg_n;
  logic [DEN_W-1:0]      seg_d;
  logic [STEP_BITS-1:0]  n_eff;
  logic                  accept;
  logic                  seg_end;
  logic                  div_start;
  logic                  busy_dx, busy_dy, busy_sx, busy_sy;
  div_res_t              res_dx, res_dy, res_sx, res_sy;
  logic signed [NUM_W-1:0] num_dx, num_dy, num_sx, num_sy;

  // Second difference of the control polygon: p0 - 2*p1 + p2.
  function automatic logic signed [COORD_BITS+1:0] curvature(
    input logic [COORD_BITS-1:0] p0,
    input logic [COORD_BITS-1:0] p1,
    input logic [COORD_BITS-1:0] p2
  );
    return $signed({2'b00, p0}) - $signed({1'b0, p1, 1'b0}) + $signed({2'b00, p2});
  endfunction

  // First forward difference of the scaled numerator: 2^F * (2n(p1-p0) + curvature).
  function automatic logic signed [NUM_W-1:0] slope_num(
    input logic [COORD_BITS-1:0] p0,
    input logic [COORD_BITS-1:0] p1,
    input logic [COORD_BITS-1:0] p2,
    input logic [STEP_BITS-1:0]  n
  );
    logic signed [COORD_BITS:0]             diff;
    logic signed [COORD_BITS+STEP_BITS+1:0] prod;
    logic signed [NUM_W-1:0]                sum;
    diff = $signed({1'b0, p1}) - $signed({1'b0, p0});
    prod = (COORD_BITS+STEP_BITS+2)'(diff) * $signed({{(COORD_BITS+2){1'b0}}, n});
    sum  = NUM_W'(prod <<< 1) + NUM_W'(curvature(p0, p1, p2));
    return sum <<< FRAC_BITS;
  endfunction

  assign accept  = push && !full;
  assign full    = (state != F_IDLE);
  assign seg_end = accept && (item.kind == KIND_POINT) && (phase == PH_CTRL);
  assign n_eff   = (steps == '0) ? STEP_BITS'(1) : steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      phase     <= PH_EMPTY;
      start_x   <= '0;
      start_y   <= '0;
      control_x <= '0;
      control_y <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (item.kind == KIND_CLEAR) begin
          phase <= PH_EMPTY;
        end else if (phase == PH_START) begin
          control_x <= item.point_x;
          control_y <= item.point_y;
          phase     <= PH_CTRL;
        end else begin
          start_x <= item.point_x;
          start_y <= item.point_y;
          phase   <= PH_START;
        end
      end
    end
  end

  // The old start point is kept aside; the new end point becomes the next start.
  always_ff @(posedge clk) begin
    if (seg_end) begin
      seg_x0 <= start_x;
      seg_y0 <= start_y;
      seg_n  <= n_eff;
      seg_d  <= DEN_W'(n_eff) * DEN_W'(n_eff);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (seg_end) begin
          state_next = F_PREP;
        end
      end
      F_PREP: begin
        state_next = F_DIV;
      end
      F_DIV: begin
        if (!(busy_dx || busy_dy || busy_sx || busy_sy)) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!job_full) begin
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  assign div_start = (state == F_PREP);

  assign num_dx = slope_num(seg_x0, control_x, start_x, seg_n);
  assign num_dy = slope_num(seg_y0, control_y, start_y, seg_n);
  assign num_sx = NUM_W'(curvature(seg_x0, control_x, start_x)) <<< (FRAC_BITS + 1);
  assign num_sy = NUM_W'(curvature(seg_y0, control_y, start_y)) <<< (FRAC_BITS + 1);

  qbt_div u_div_dx (
    .clk(clk), .rst(rst), .start(div_start), .num(num_dx), .den(seg_d),
    .busy(busy_dx), .res(res_dx)
  );
  qbt_div u_div_dy (
    .clk(clk), .rst(rst), .start(div_start), .num(num_dy), .den(seg_d),
    .busy(busy_dy), .res(res_dy)
  );
  qbt_div u_div_sx (
    .clk(clk), .rst(rst), .start(div_start), .num(num_sx), .den(seg_d),
    .busy(busy_sx), .res(res_sx)
  );
  qbt_div u_div_sy (
    .clk(clk), .rst(rst), .start(div_start), .num(num_sy), .den(seg_d),
    .busy(busy_sy), .res(res_sy)
  );

  assign job_push = (state == F_PUSH) && !job_full;

  always_comb begin
    job.n    = seg_n;
    job.d    = seg_d;
    job.x.q0 = Q0_W'(seg_x0) << FRAC_BITS;
    job.x.dq = res_dx.quo;
    job.x.dr = res_dx.rem;
    job.x.sq = res_sx.quo;
    job.x.sr = res_sx.rem;
    job.y.q0 = Q0_W'(seg_y0) << FRAC_BITS;
    job.y.dq = res_dy.quo;
    job.y.dr = res_dy.rem;
    job.y.sq = res_sy.quo;
    job.y.sr = res_sy.rem;
  end

endmodule

`default_nettype wire

// ===== src/qbt_queue.sv =====
// Short job queue between the front end and the sample stepper.
// Depends on qbt_pkg.
`default_nettype none

module qbt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  qbt_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output qbt_pkg::job_t rdata,
  output logic          empty
);
  import qbt_pkg::*;

  localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOB_DEPTH + 1);

  job_t             mem [JOB_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(JOB_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/qbt_back.sv =====
// Sample stepper: walks a segment by exact forward differences into a small result
// buffer, one sample per cycle while that buffer has room. Depends on qbt_pkg.
`default_nettype none

module qbt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_empty,
  output logic             job_pop,
  input  qbt_pkg::job_t    job,
  output logic             empty,
  input  logic             pop,
  output qbt_pkg::result_t result
);
  import qbt_pkg::*;

  localparam int OPTR_W = (OBUF_DEPTH > 1) ? $clog2(OBUF_DEPTH) : 1;
  localparam int OCNT_W = $clog2(OBUF_DEPTH + 1);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } bstate_t;

  // Sample kept as quotient and remainder of a division by n*n.
  typedef struct packed {
    logic signed [ACC_W-1:0] q;
    logic [DEN_W-1:0]        r;
    logic signed [ACC_W-1:0] dq;
    logic [DEN_W-1:0]        dr;
    logic signed [ACC_W-1:0] sq;
    logic [DEN_W-1:0]        sr;
  } axis_run_t;

  bstate_t              state;
  axis_run_t            ax, ay;
  logic [STEP_BITS-1:0] j, n;
  logic [DEN_W-1:0]     d;
  result_t              sample;
  logic                 run_push;
  logic                 last;

  result_t               obuf [OBUF_DEPTH];
  logic [OPTR_W-1:0]     owr, ord;
  logic [OCNT_W-1:0]     ocount;
  logic                  opop;

  function automatic axis_run_t step_axis(input axis_run_t a, input logic [DEN_W-1:0] den);
    axis_run_t      o;
    logic [DEN_W:0] rs, drs;
    logic           c, c2;
    rs   = {1'b0, a.r} + {1'b0, a.dr};
    c    = rs >= {1'b0, den};
    drs  = {1'b0, a.dr} + {1'b0, a.sr};
    c2   = drs >= {1'b0, den};
    o.r  = c ? DEN_W'(rs - {1'b0, den}) : rs[DEN_W-1:0];
    o.q  = a.q + a.dq + $signed({{(ACC_W-1){1'b0}}, c});
    o.dr = c2 ? DEN_W'(drs - {1'b0, den}) : drs[DEN_W-1:0];
    o.dq = a.dq + a.sq + $signed({{(ACC_W-1){1'b0}}, c2});
    o.sq = a.sq;
    o.sr = a.sr;
    return o;
  endfunction

  function automatic axis_run_t load_axis(input axis_job_t a, input logic [DEN_W-1:0] den);
    axis_run_t o;
    o.q  = $signed({{(ACC_W-Q0_W){1'b0}}, a.q0});
    o.r  = den >> 1;
    o.dq = a.dq;
    o.dr = a.dr;
    o.sq = a.sq;
    o.sr = a.sr;
    return o;
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat(input logic signed [ACC_W-1:0] q);
    return (q > $signed(ACC_W'(OUT_MAX))) ? OUT_MAX : q[SAMPLE_W-1:0];
  endfunction

  assign job_pop  = (state == B_IDLE) && !job_empty;
  assign run_push = (state == B_RUN) && (ocount != OCNT_W'(OBUF_DEPTH));
  assign last     = (j == n);

  assign sample.sample_x    = sat(ax.q);
  assign sample.sample_y    = sat(ay.q);
  assign sample.last_sample = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (job_pop) begin
            state <= B_RUN;
          end
        end
        B_RUN: begin
          if (run_push && last) begin
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      ax <= load_axis(job.x, job.d);
      ay <= load_axis(job.y, job.d);
      j  <= '0;
      n  <= job.n;
      d  <= job.d;
    end else if (run_push && !last) begin
      ax <= step_axis(ax, d);
      ay <= step_axis(ay, d);
      j  <= j + 1'b1;
    end
  end

  // Result buffer.
  assign empty  = (ocount == '0);
  assign opop   = pop && !empty;
  assign result = obuf[ord];

  always_ff @(posedge clk) begin
    if (rst) begin
      owr    <= '0;
      ord    <= '0;
      ocount <= '0;
    end else begin
      if (run_push) begin
        owr <= (owr == OPTR_W'(OBUF_DEPTH - 1)) ? '0 : owr + 1'b1;
      end
      if (opop) begin
        ord <= (ord == OPTR_W'(OBUF_DEPTH - 1)) ? '0 : ord + 1'b1;
      end
      if (run_push && !opop) begin
        ocount <= ocount + 1'b1;
      end else if (opop && !run_push) begin
        ocount <= ocount - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_push) begin
      obuf[owr] <= sample;
    end
  end

endmodule

`default_nettype wire

// ===== src/quadratic_bezier_tessellator.sv =====
// Top level of the quadratic Bezier tessellator: configuration register and block wiring.
// Depends on qbt_pkg, qbt_front, qbt_queue and qbt_back.
`default_nettype none

// Points are pushed one transaction at a time and chained into quadratic segments that
// share end points: the first point is a start, the next a control point, and the point
// after that ends the segment and starts the next one, which again takes a control point.
// A clear transaction forgets all points and produces nothing. Each segment end yields
// segment_steps+1 samples in 1/64 pixel, rounded to nearest, with last_sample set on the
// final one; a segment_steps value of zero acts as one. Points that do not end a segment
// and clears leave the front end ready. A segment end first occupies the front end while
// the four bit-serial dividers (one quotient bit per cycle) turn the curve into exact
// forward differences; the job then waits in a two-entry queue for the stepper, which
// loads it and then emits one sample per cycle while the result buffer has room.
// Front end and stepper overlap, so the front end can prepare the next segment while
// the stepper samples. Results wait in a two-entry buffer, so a stalled consumer holds
// the stepper, and the front end once the job queue is full. segment_steps resets to 40.
// segment_steps sits at byte address 0 of the register port and must be written only
// while no results are outstanding. There is no clearing pass after reset.

module quadratic_bezier_tessellator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qbt_pkg::PADDR_W-1:0]   paddr,
  input  logic [qbt_pkg::PDATA_W-1:0]   pwdata,
  output logic [qbt_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  qbt_pkg::item_t                item,
  output logic                          empty,
  input  logic                          pop,
  output qbt_pkg::result_t              result
);
  import qbt_pkg::*;

  logic [STEP_BITS-1:0] segment_steps;
  logic                 reg_hit;
  logic                 job_push, job_full, job_pop, job_empty;
  job_t                 job_in, job_out;

  // Register port: no wait states; the upper address bits pick the register.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_STEPS);
  assign prdata  = reg_hit ? {{(PDATA_W-STEP_BITS){1'b0}}, segment_steps} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_steps <= DEFAULT_STEPS;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      segment_steps <= pwdata[STEP_BITS-1:0];
    end
  end

  // The front end classifies each transaction and builds a stepper job on segment ends.
  qbt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .steps    (segment_steps),
    .push     (push),
    .full     (full),
    .item     (item),
    .job_push (job_push),
    .job_full (job_full),
    .job      (job_in)
  );

  // Jobs queue up so the front end can prepare the next segment during sampling.
  qbt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  // The stepper emits one sample per cycle into the result buffer while it has room.
  qbt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (job_out),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // A clear never starts segment work, so the front end stays ready after it.
  a_clear_keeps_ready: assert property (@(posedge clk) disable iff (rst)
    (push && !full && (item.kind == KIND_CLEAR)) |=> !full)
    else $error("front end went busy after a clear transaction");

  // The front end only hands over a job when the queue has room.
  a_job_push_room: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full)
    else $error("job pushed into a full queue");

  // The stepper only takes a job that is present.
  a_job_pop_present: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !job_empty)
    else $error("job popped from an empty queue");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result buffer not empty after reset");

endmodule

`default_nettype wire
